// File: hdl/drac_pkg.sv
// Shared types and constants for the debug access region checker.
// Used by drac_cell, the top level and the checker; depends on nothing.
`default_nettype none

package drac_pkg;

  localparam int REGION_ENTRIES = 8;
  localparam int COUNT_BITS     = 16;

  // Cell index width and the width used to match a load against a cell.
  localparam int IDX_W = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;
  localparam int CMP_W = (IDX_W > 3) ? IDX_W : 3;

  // A region end is base + (count << 31) at most, held without wrap.
  localparam int END_BITS = ((COUNT_BITS + 31) > 32 ? (COUNT_BITS + 31) : 32) + 1;

  typedef enum logic [2:0] {
    FN_LOAD = 3'd0,
    FN_RD32 = 3'd1,
    FN_WR32 = 3'd2,
    FN_RD64 = 3'd3,
    FN_WR64 = 3'd4,
    FN_SPAN = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_OUTSIDE    = 2'd2,
    ST_READ_ONLY  = 2'd3
  } status_t;

  // The word that travels down the row of cells, with its partial result.
  typedef struct packed {
    logic                  vld;
    func_t                 fn;
    logic [31:0]           addr;
    logic [32:0]           addr_end;
    logic [2:0]            idx;
    logic [31:0]           base;
    logic [COUNT_BITS-1:0] count;
    logic [4:0]            shift;
    logic                  ro;
    logic                  done;
    logic                  ended;
    logic                  seen;
    logic                  lo;
    logic [END_BITS-1:0]   last_end;
    status_t               st;
    logic [2:0]            hit;
  } word_t;

  function automatic logic is_access(func_t fn);
    return fn inside {FN_RD32, FN_WR32, FN_RD64, FN_WR64};
  endfunction

  function automatic logic is_write(func_t fn);
    return fn inside {FN_WR32, FN_WR64};
  endfunction

endpackage

`default_nettype wire

// File: hdl/drac_cell.sv
// One cell of the region row: holds one table entry and checks the passing word.
// Depends on drac_pkg.
`default_nettype none

module drac_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire logic [drac_pkg::IDX_W-1:0]     cell_idx,
  input  wire drac_pkg::word_t                word_in,
  output drac_pkg::word_t                     word_out
);

  logic                          valid;
  logic [31:0]                   base;
  logic [drac_pkg::END_BITS-1:0] reg_end;
  logic                          ro;

  logic                          load_here;
  logic                          live;
  logic                          covers;
  drac_pkg::word_t               word_next;

  assign load_here = word_in.vld && (word_in.fn == drac_pkg::FN_LOAD) &&
                     (drac_pkg::CMP_W'(word_in.idx) == drac_pkg::CMP_W'(cell_idx));

  // A cell counts only while no empty slot has been passed before it.
  assign live   = valid && !word_in.ended;
  assign covers = (word_in.addr >= base) &&
                  (drac_pkg::END_BITS'(word_in.addr_end) <= reg_end);

  always_comb begin
    word_next = word_in;
    if (word_in.vld) begin
      if (drac_pkg::is_access(word_in.fn) && !word_in.done && live && covers) begin
        word_next.done = 1'b1;
        word_next.hit  = 3'(cell_idx);
        word_next.st   = (drac_pkg::is_write(word_in.fn) && ro) ?
                         drac_pkg::ST_READ_ONLY : drac_pkg::ST_OK;
      end
      if (word_in.fn == drac_pkg::FN_SPAN && live) begin
        word_next.seen     = 1'b1;
        word_next.last_end = reg_end;
        if (cell_idx == '0) begin
          word_next.lo = (word_in.addr >= base);
        end
      end
      word_next.ended = word_in.ended || !valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      word_out.vld <= 1'b0;
    end else if (advance) begin
      word_out <= word_next;
      if (load_here) begin
        valid <= (word_in.count != '0);
      end
    end
  end

  // The end is formed once at load time so a check needs only compares.
  always_ff @(posedge clk) begin
    if (advance && load_here) begin
      base    <= word_in.base;
      reg_end <= drac_pkg::END_BITS'(word_in.base) +
                 (drac_pkg::END_BITS'(word_in.count) << word_in.shift);
      ro      <= word_in.ro;
    end
  end

endmodule

`default_nettype wire

// File: hdl/debug_access_region_checker_core.sv
// Top level of the debug access region checker: a row of drac_cell stages
// and an output register. Depends on drac_pkg and drac_cell.
//
//   channel | signals                                  | direction
//   in      | in_valid, in_ready, func .. entry_read_only | into block
//   out     | out_valid, out_ready, status, region_hit | out of block
//
// One word is accepted per cycle unless the row is frozen; its result passes a register
// in each cell of the row and then the output register.
// Loads and checks flow through the same row in order, so a check sees every
// load accepted before it. Reset empties the table and drops words in flight;
// in_ready is low while reset is held.
// A result held with out_ready low freezes the whole row and drops in_ready.
`default_nettype none

module debug_access_region_checker_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic [31:0] address,
  input  wire logic [2:0]  entry_index,
  input  wire logic [31:0] entry_base,
  input  wire logic [15:0] entry_count,
  input  wire logic [4:0]  entry_shift,
  input  wire logic        entry_read_only,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [2:0]       region_hit
);

  localparam int N = drac_pkg::REGION_ENTRIES;

  drac_pkg::word_t chain [N+1];
  drac_pkg::func_t fn;
  logic            advance;
  logic [1:0]      status_next;
  logic [2:0]      hit_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && !rst;
  assign fn       = drac_pkg::func_t'(func);

  always_comb begin
    chain[0]          = '0;
    chain[0].vld      = in_valid;
    chain[0].fn       = fn;
    chain[0].addr     = address;
    chain[0].addr_end = {1'b0, address} +
                        (((fn == drac_pkg::FN_RD64) || (fn == drac_pkg::FN_WR64)) ?
                         33'd8 : 33'd4);
    chain[0].idx      = entry_index;
    chain[0].base     = entry_base;
    chain[0].count    = drac_pkg::COUNT_BITS'(entry_count);
    chain[0].shift    = entry_shift;
    chain[0].ro       = entry_read_only;
    chain[0].st       = drac_pkg::ST_MISALIGNED;
    // A misaligned access is settled here and passes the cells untouched.
    chain[0].done     = drac_pkg::is_access(fn) && (address[1:0] != 2'b00);
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    drac_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cell_idx (drac_pkg::IDX_W'(k)),
      .word_in  (chain[k]),
      .word_out (chain[k+1])
    );
  end

  always_comb begin
    status_next = drac_pkg::ST_OUTSIDE;
    hit_next    = 3'd0;
    case (chain[N].fn)
      drac_pkg::FN_LOAD: begin
        status_next = drac_pkg::ST_OK;
      end
      drac_pkg::FN_RD32, drac_pkg::FN_WR32, drac_pkg::FN_RD64, drac_pkg::FN_WR64: begin
        if (chain[N].done) begin
          status_next = chain[N].st;
          hit_next    = chain[N].hit;
        end
      end
      drac_pkg::FN_SPAN: begin
        if (chain[N].seen && chain[N].lo &&
            (drac_pkg::END_BITS'(chain[N].addr) < chain[N].last_end)) begin
          status_next = drac_pkg::ST_OK;
        end
      end
      default: begin
        status_next = drac_pkg::ST_OUTSIDE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chain[N].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status     <= status_next;
      region_hit <= hit_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/drac_checker.sv
// Port-level checks for the debug access region checker, bound to the top level.
// Depends on drac_pkg and debug_access_region_checker_core.
`default_nettype none

module drac_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status,
  input wire logic [2:0] region_hit
);

  // A held result keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(region_hit))
    else $error("result word changed while stalled");

  // The row moves exactly when the output register can take a word.
  a_ready_tie: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output register");

  // Only a decision by a region names one.
  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == drac_pkg::ST_MISALIGNED || status == drac_pkg::ST_OUTSIDE)
      |-> region_hit == 3'd0)
    else $error("region_hit set without a deciding region");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word present after reset");

endmodule

bind debug_access_region_checker_core drac_checker u_drac_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .region_hit (region_hit)
);

`default_nettype wire
